// ===== hw/rtl/tpoc_pkg.sv =====
`default_nettype none

package tpoc_pkg;

   // Power status codes
   localparam logic [2:0] ST_OFF      = 3'd0;
   localparam logic [2:0] ST_FWD      = 3'd1;
   localparam logic [2:0] ST_REV      = 3'd2;
   localparam logic [2:0] ST_TRIP_FWD = 3'd3;
   localparam logic [2:0] ST_TRIP_REV = 3'd4;

   // Item commands
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_SET    = 1'b1;

   // Requested states; the last code is unassigned and ignored
   localparam logic [1:0] REQ_OFF    = 2'd0;
   localparam logic [1:0] REQ_FWD    = 2'd1;
   localparam logic [1:0] REQ_REV    = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // Power modes
   localparam logic [2:0] MODE_NONE    = 3'd0;
   localparam logic [2:0] MODE_EXT_DCC = 3'd1;
   localparam logic [2:0] MODE_DC      = 3'd3;
   localparam logic [2:0] MODE_DC_REV  = 3'd4;

   // Register indexes
   localparam logic [1:0] REG_POWER_MODE      = 2'd0;
   localparam logic [1:0] REG_OVERLOAD_LIMIT  = 2'd1;
   localparam logic [1:0] REG_COOLDOWN_US     = 2'd2;
   localparam logic [1:0] REG_EXT_ENABLE_USED = 2'd3;

   // Register reset values
   localparam logic [2:0]  RST_POWER_MODE      = 3'd0;
   localparam logic [22:0] RST_OVERLOAD_LIMIT  = 23'd8388607;
   localparam logic [31:0] RST_COOLDOWN_US     = 32'd100000;
   localparam logic        RST_EXT_ENABLE_USED = 1'b0;

   typedef struct packed {
      logic [2:0]  power_mode;
      logic [22:0] overload_limit;
      logic [31:0] cooldown_us;
      logic        ext_enable_used;
   } cfg_type;

   typedef struct packed {
      logic               cmd;
      logic signed [23:0] current;
      logic [1:0]         requested_state;
      logic [31:0]        now_us;
      logic               ext_enable;
   } item_type;

   typedef struct packed {
      logic [2:0]  power_status;
      logic [31:0] trip_time;
      logic        reverse_level;
   } state_type;

   typedef struct packed {
      logic       drive_en;
      logic       reverse_out;
      logic [2:0] power_status;
      logic       tripped_now;
      logic       recovered_now;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tpoc_csr.sv =====
`default_nettype none

module tpoc_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            psel,
   input  wire logic            penable,
   input  wire logic            pwrite,
   input  wire logic [3:0]      paddr,
   input  wire logic [31:0]     pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output tpoc_pkg::cfg_type    cfg,
   output logic                 mode_write
);
   import tpoc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;

   // Decode register writes
   always_comb begin
      cfg_in     = cfg_ff;
      mode_write = 1'b0;
      if (wr_en) begin
         unique case (reg_idx)
            REG_POWER_MODE: begin
               cfg_in.power_mode = pwdata[2:0];
               mode_write        = 1'b1;
            end
            REG_OVERLOAD_LIMIT:  cfg_in.overload_limit  = pwdata[22:0];
            REG_COOLDOWN_US:     cfg_in.cooldown_us     = pwdata;
            REG_EXT_ENABLE_USED: cfg_in.ext_enable_used = pwdata[0];
            default: ;
         endcase
      end
   end

   // Hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_mode      <= RST_POWER_MODE;
         cfg_ff.overload_limit  <= RST_OVERLOAD_LIMIT;
         cfg_ff.cooldown_us     <= RST_COOLDOWN_US;
         cfg_ff.ext_enable_used <= RST_EXT_ENABLE_USED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         REG_POWER_MODE:      prdata = {29'd0, cfg_ff.power_mode};
         REG_OVERLOAD_LIMIT:  prdata = {9'd0, cfg_ff.overload_limit};
         REG_COOLDOWN_US:     prdata = cfg_ff.cooldown_us;
         REG_EXT_ENABLE_USED: prdata = {31'd0, cfg_ff.ext_enable_used};
         default:             prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tpoc_step.sv =====
`default_nettype none

module tpoc_step (
   input  tpoc_pkg::cfg_type    cfg,
   input  tpoc_pkg::state_type  st,
   input  tpoc_pkg::item_type   item,
   output tpoc_pkg::state_type  st_next,
   output tpoc_pkg::result_type res
);
   import tpoc_pkg::*;

   logic        cur_gt, cur_lt, is_on, is_trip, cool_done;
   logic [31:0] elapsed;
   logic        tripped, recovered;

   // Reverse level for a channel turned on in a direction
   function automatic logic rev_level(input logic [2:0] mode, input logic [2:0] dir,
                                      input logic old);
      logic lvl;
      lvl = old;
      if (mode == MODE_DC)
         lvl = (dir == ST_REV);
      else if (mode == MODE_DC_REV)
         lvl = (dir == ST_FWD);
      return lvl;
   endfunction

   // Compare current to the non-negative limit
   assign cur_gt = !item.current[23] && (item.current[22:0] > cfg.overload_limit);
   assign cur_lt = item.current[23] || (item.current[22:0] < cfg.overload_limit);

   assign is_on     = (st.power_status == ST_FWD) || (st.power_status == ST_REV);
   assign is_trip   = (st.power_status == ST_TRIP_FWD) || (st.power_status == ST_TRIP_REV);
   assign elapsed   = item.now_us - st.trip_time;
   assign cool_done = elapsed > cfg.cooldown_us;

   // Update power state; a trip never recovers on the same item
   always_comb begin
      st_next   = st;
      tripped   = 1'b0;
      recovered = 1'b0;
      if (item.cmd == CMD_SET) begin
         case (item.requested_state) inside
            REQ_OFF: st_next.power_status = ST_OFF;
            REQ_FWD, REQ_REV: begin
               st_next.power_status  = {1'b0, item.requested_state};
               st_next.trip_time     = item.now_us;
               st_next.reverse_level = rev_level(cfg.power_mode,
                                                 {1'b0, item.requested_state},
                                                 st.reverse_level);
            end
            default: ;
         endcase
      end else if (cfg.power_mode != MODE_NONE) begin
         if (is_on && cur_gt) begin
            st_next.trip_time    = item.now_us;
            st_next.power_status = (st.power_status == ST_FWD) ? ST_TRIP_FWD : ST_TRIP_REV;
            tripped              = 1'b1;
         end else if (is_trip && cool_done && cur_lt) begin
            st_next.power_status  = (st.power_status == ST_TRIP_FWD) ? ST_FWD : ST_REV;
            st_next.trip_time     = item.now_us;
            st_next.reverse_level = rev_level(cfg.power_mode, st_next.power_status,
                                              st.reverse_level);
            recovered             = 1'b1;
         end
      end
   end

   // Form the result from the updated state
   always_comb begin
      res.drive_en = ((st_next.power_status == ST_FWD) || (st_next.power_status == ST_REV))
                     && (cfg.power_mode != MODE_NONE)
                     && !((cfg.power_mode == MODE_EXT_DCC) && cfg.ext_enable_used
                          && !item.ext_enable);
      res.reverse_out   = st_next.reverse_level;
      res.power_status  = st_next.power_status;
      res.tripped_now   = tripped;
      res.recovered_now = recovered;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/track_power_overload_controller_core.sv =====
`default_nettype none

// Track power overload controller, one channel. Each item is either a current
// sample with a microsecond timestamp (cmd 0) or a power state request (cmd 1),
// and each item yields exactly one result carrying the state after that item.
// Items flow at one per cycle while rsp_stall holds no result: an item is
// registered on entry, the state update is a single compare-and-subtract pass
// from that register into the result register, and rsp_valid rises when the
// result register is loaded. While a result waits under rsp_stall the block
// takes one more item into its input register and then raises req_stall.
// Registers sit on an
// APB-style port at byte addresses 0 (power_mode), 4 (overload_limit),
// 8 (cooldown_us) and 12 (ext_enable_used); writing power_mode forces the state
// off. Write registers only while no item is in flight.
module track_power_overload_controller_core (
   input  wire logic               clock,
   input  wire logic               reset,
   // item channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_cmd,
   input  wire logic signed [23:0] req_current,
   input  wire logic [1:0]         req_requested_state,
   input  wire logic [31:0]        req_now_us,
   input  wire logic               req_ext_enable,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_drive_en,
   output logic                    rsp_reverse_out,
   output logic [2:0]              rsp_power_status,
   output logic                    rsp_tripped_now,
   output logic                    rsp_recovered_now,
   // configuration
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [3:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import tpoc_pkg::*;

   cfg_type    cfg;
   logic       mode_write;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   result_type res_ff, res_in, res_calc;
   logic       out_valid_ff, out_valid_in;
   state_type  state_ff, state_in, state_calc;
   logic       out_free, advance, req_take;

   tpoc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .cfg        (cfg),
      .mode_write (mode_write)
   );

   tpoc_step u_step (
      .cfg     (cfg),
      .st      (state_ff),
      .item    (item_ff),
      .st_next (state_calc),
      .res     (res_calc)
   );

   // Pipeline control
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      item_in      = req_take ? {req_cmd, req_current, req_requested_state,
                                 req_now_us, req_ext_enable} : item_ff;
      in_valid_in  = req_take || (in_valid_ff && !advance);
      res_in       = advance ? res_calc : res_ff;
      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   // Advance state; a power mode write forces it off
   always_comb begin
      state_in = advance ? state_calc : state_ff;
      if (mode_write)
         state_in.power_status = ST_OFF;
   end

   // Hold control, state and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      item_ff <= item_in;
      res_ff  <= res_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_drive_en      = res_ff.drive_en;
   assign rsp_reverse_out   = res_ff.reverse_out;
   assign rsp_power_status  = res_ff.power_status;
   assign rsp_tripped_now   = res_ff.tripped_now;
   assign rsp_recovered_now = res_ff.recovered_now;

endmodule

`default_nettype wire

// ===== hw/rtl/tpoc_checker.sv =====
`default_nettype none

module tpoc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_drive_en,
   input wire logic [2:0] rsp_power_status,
   input wire logic       rsp_tripped_now,
   input wire logic       rsp_recovered_now
);
   import tpoc_pkg::*;

   // A trip and a recovery never come from one item
   a_trip_xor_recover: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tripped_now && rsp_recovered_now))
      else $error("trip and recovery on one item");

   // Enable only while powered on
   a_enable_on: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_drive_en) |-> (rsp_power_status == ST_FWD || rsp_power_status == ST_REV))
      else $error("enable while not powered on");

   // A trip leaves a tripped status
   a_trip_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tripped_now) |->
         (rsp_power_status == ST_TRIP_FWD || rsp_power_status == ST_TRIP_REV))
      else $error("trip without tripped status");

   // A recovery leaves an on status
   a_recover_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_recovered_now) |->
         (rsp_power_status == ST_FWD || rsp_power_status == ST_REV))
      else $error("recovery without on status");

   // Hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_power_status)))
      else $error("stalled result changed");

endmodule

bind track_power_overload_controller_core tpoc_checker u_tpoc_checker (.*);

`default_nettype wire

// ===== dv/tb_track_power_overload_controller_core.sv =====
module tb_track_power_overload_controller_core;
   import tpoc_pkg::*;

   localparam int HANG_LIMIT   = 5000;
   localparam int SEGMENTS     = 8;
   localparam int SEGMENT_LEN  = 58;
   localparam int PRINT_CAP    = 200;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_cmd = CMD_SAMPLE;
   logic signed [23:0] req_current = '0;
   logic [1:0]         req_requested_state = REQ_OFF;
   logic [31:0]        req_now_us = '0;
   logic               req_ext_enable = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_drive_en;
   logic               rsp_reverse_out;
   logic [2:0]         rsp_power_status;
   logic               rsp_tripped_now;
   logic               rsp_recovered_now;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [3:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   track_power_overload_controller_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_current(req_current), .req_requested_state(req_requested_state),
      .req_now_us(req_now_us), .req_ext_enable(req_ext_enable),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_drive_en(rsp_drive_en),
      .rsp_reverse_out(rsp_reverse_out), .rsp_power_status(rsp_power_status),
      .rsp_tripped_now(rsp_tripped_now), .rsp_recovered_now(rsp_recovered_now),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Channel copy: registers and state as the block should hold them
   logic [2:0]  chan_mode;
   logic [22:0] chan_limit;
   logic [31:0] chan_cooldown;
   logic        chan_ext_used;
   logic [2:0]  chan_status;
   logic [31:0] chan_trip_time;
   logic        chan_rev_level;

   result_type  pending_track_outputs[$];
   int          output_errors = 0;
   int          outputs_seen = 0;
   int          quiet_cycles = 0;

   // Stimulus knobs
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int          segment_index = 0;
   logic [22:0] segment_limit = '0;
   logic [31:0] now_track = '0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver back-pressure, redrawn every cycle
   initial begin
      forever begin
         @(negedge clock);
         rsp_stall = ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   task automatic flag_output_error(input string what, input logic [31:0] want,
                                    input logic [31:0] got);
      if (output_errors < PRINT_CAP)
         $display("output %0d: %s expected %0h got %0h", outputs_seen, what, want, got);
      output_errors++;
   endtask

   task automatic drive_power_on(input logic [2:0] dir, input logic [31:0] now);
      chan_trip_time = now;
      if (chan_mode == MODE_DC)
         chan_rev_level = (dir == ST_REV);
      else if (chan_mode == MODE_DC_REV)
         chan_rev_level = (dir == ST_FWD);
      chan_status = dir;
   endtask

   task automatic apply_register_write(input logic [1:0] idx, input logic [31:0] data);
      case (idx)
         REG_POWER_MODE: begin
            chan_mode   = data[2:0];
            chan_status = ST_OFF;
         end
         REG_OVERLOAD_LIMIT:  chan_limit    = data[22:0];
         REG_COOLDOWN_US:     chan_cooldown = data;
         REG_EXT_ENABLE_USED: chan_ext_used = data[0];
         default: ;
      endcase
   endtask

   // Advance the channel by one item and form the result it owes
   task automatic step_power_channel(input item_type it, output result_type res);
      logic signed [24:0] cur;
      logic signed [24:0] lim;
      logic [31:0]        elapsed;
      res = '0;
      cur = {it.current[23], it.current};
      lim = {2'b00, chan_limit};
      if (it.cmd == CMD_SET) begin
         if (it.requested_state == REQ_OFF)
            chan_status = ST_OFF;
         else if (it.requested_state == REQ_FWD)
            drive_power_on(ST_FWD, it.now_us);
         else if (it.requested_state == REQ_REV)
            drive_power_on(ST_REV, it.now_us);
      end else if (chan_mode != MODE_NONE) begin
         if ((chan_status == ST_FWD || chan_status == ST_REV) && cur > lim) begin
            chan_trip_time  = it.now_us;
            chan_status     = (chan_status == ST_FWD) ? ST_TRIP_FWD : ST_TRIP_REV;
            res.tripped_now = 1'b1;
         end
         if (chan_status == ST_TRIP_FWD || chan_status == ST_TRIP_REV) begin
            elapsed = it.now_us - chan_trip_time;
            if (elapsed > chan_cooldown && cur < lim) begin
               drive_power_on((chan_status == ST_TRIP_FWD) ? ST_FWD : ST_REV, it.now_us);
               res.recovered_now = 1'b1;
            end
         end
      end
      res.drive_en = (chan_status == ST_FWD || chan_status == ST_REV)
                     && chan_mode != MODE_NONE
                     && !(chan_mode == MODE_EXT_DCC && chan_ext_used && !it.ext_enable);
      res.reverse_out  = chan_rev_level;
      res.power_status = chan_status;
   endtask

   // Sample both channels and the register port at each rising edge
   always @(posedge clock) begin : observe
      item_type   seen;
      result_type want;
      logic       progress;
      if (reset) begin
         chan_mode      = RST_POWER_MODE;
         chan_limit     = RST_OVERLOAD_LIMIT;
         chan_cooldown  = RST_COOLDOWN_US;
         chan_ext_used  = RST_EXT_ENABLE_USED;
         chan_status    = ST_OFF;
         chan_trip_time = '0;
         chan_rev_level = 1'b0;
         quiet_cycles   = 0;
      end else begin
         progress = 1'b0;
         if (psel && penable && pwrite && pready) begin
            apply_register_write(paddr[3:2], pwdata);
            progress = 1'b1;
         end
         // accept an item: predict before any result of this edge is checked
         if (req_valid && !req_stall) begin
            seen.cmd             = req_cmd;
            seen.current         = req_current;
            seen.requested_state = req_requested_state;
            seen.now_us          = req_now_us;
            seen.ext_enable      = req_ext_enable;
            step_power_channel(seen, want);
            pending_track_outputs.push_back(want);
            progress = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            progress = 1'b1;
            if (pending_track_outputs.size() == 0) begin
               flag_output_error("unexpected output", 0, 0);
            end else begin
               want = pending_track_outputs.pop_front();
               if (rsp_drive_en !== want.drive_en)
                  flag_output_error("drive_en", 32'(want.drive_en), 32'(rsp_drive_en));
               if (rsp_reverse_out !== want.reverse_out)
                  flag_output_error("reverse_out", 32'(want.reverse_out),
                                    32'(rsp_reverse_out));
               if (rsp_power_status !== want.power_status)
                  flag_output_error("power_status", 32'(want.power_status),
                                    32'(rsp_power_status));
               if (rsp_tripped_now !== want.tripped_now)
                  flag_output_error("tripped_now", 32'(want.tripped_now),
                                    32'(rsp_tripped_now));
               if (rsp_recovered_now !== want.recovered_now)
                  flag_output_error("recovered_now", 32'(want.recovered_now),
                                    32'(rsp_recovered_now));
            end
            outputs_seen++;
         end
         // hang detection
         quiet_cycles = progress ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic item_type make_item(input logic cmd, input int cur,
                                          input logic [1:0] req, input logic [31:0] now,
                                          input logic ext);
      item_type it;
      it.cmd             = cmd;
      it.current         = cur[23:0];
      it.requested_state = req;
      it.now_us          = now;
      it.ext_enable      = ext;
      return it;
   endfunction

   // Present one item, holding it until taken; called and returns at a falling edge
   task automatic send_item(input item_type it);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_cmd             = it.cmd;
      req_current         = it.current;
      req_requested_state = it.requested_state;
      req_now_us          = it.now_us;
      req_ext_enable      = it.ext_enable;
      req_valid           = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // Drop valid and let every owed output drain before touching registers
   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_track_outputs.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic test_power_requests();
      wait_drained();
      csr_write(REG_POWER_MODE, 32'(MODE_DC));
      csr_write(REG_OVERLOAD_LIMIT, 32'd1000);
      csr_write(REG_COOLDOWN_US, 32'd50);
      csr_write(REG_EXT_ENABLE_USED, 32'd0);
      send_item(make_item(CMD_SET, 0, REQ_FWD, 32'd10, 1'b1));
      send_item(make_item(CMD_SET, 0, REQ_REV, 32'd20, 1'b0));
      // the unused request code must change nothing
      send_item(make_item(CMD_SET, 0, REQ_UNUSED, 32'd30, 1'b1));
      send_item(make_item(CMD_SET, 0, REQ_OFF, 32'd40, 1'b0));
   endtask

   task automatic test_trip_and_recovery();
      wait_drained();
      csr_write(REG_POWER_MODE, 32'(MODE_DC_REV));
      send_item(make_item(CMD_SET, 0, REQ_FWD, 32'd100, 1'b0));
      // current at the limit neither trips nor recovers
      send_item(make_item(CMD_SAMPLE, 1000, REQ_OFF, 32'd200, 1'b0));
      send_item(make_item(CMD_SAMPLE, 8388607, REQ_OFF, 32'd300, 1'b1));
      send_item(make_item(CMD_SAMPLE, -8388608, REQ_OFF, 32'd350, 1'b1));
      send_item(make_item(CMD_SAMPLE, 1000, REQ_OFF, 32'd400, 1'b0));
      send_item(make_item(CMD_SAMPLE, 999, REQ_OFF, 32'd401, 1'b0));
      // cooldown measured across the timestamp wrap
      send_item(make_item(CMD_SET, 0, REQ_REV, 32'hFFFF_FFF0, 1'b1));
      send_item(make_item(CMD_SAMPLE, 1001, REQ_FWD, 32'hFFFF_FFF8, 1'b0));
      send_item(make_item(CMD_SAMPLE, 5, REQ_REV, 32'h0000_0030, 1'b1));
   endtask

   task automatic test_mode_gating();
      wait_drained();
      // mode none: requests obeyed with the output held off, samples ignored
      csr_write(REG_POWER_MODE, 32'(MODE_NONE));
      send_item(make_item(CMD_SET, 0, REQ_FWD, 32'd500, 1'b1));
      send_item(make_item(CMD_SAMPLE, 8388607, REQ_OFF, 32'd600, 1'b1));
      wait_drained();
      csr_write(REG_POWER_MODE, 32'(MODE_EXT_DCC));
      csr_write(REG_EXT_ENABLE_USED, 32'd1);
      send_item(make_item(CMD_SET, 0, REQ_FWD, 32'd700, 1'b0));
      send_item(make_item(CMD_SAMPLE, 10, REQ_OFF, 32'd710, 1'b1));
      wait_drained();
      // out-of-range mode: stored, counts as on, leaves the reverse level
      csr_write(REG_POWER_MODE, 32'hFFFF_FFFF);
      send_item(make_item(CMD_SET, 0, REQ_REV, 32'd800, 1'b0));
   endtask

   task automatic configure_segment();
      logic [31:0] data;
      logic [2:0]  mode;
      int          pick;
      wait_drained();
      pick = $urandom_range(0, 9);
      if (pick == 0)
         segment_limit = '0;
      else if (pick == 1)
         segment_limit = 23'h7F_FFFF;
      else if (pick < 8)
         segment_limit = 23'($urandom_range(0, 2000));
      else
         segment_limit = 23'($urandom_range(0, 8388607));
      data = $urandom;
      data[22:0] = segment_limit;
      csr_write(REG_OVERLOAD_LIMIT, data);
      pick = $urandom_range(0, 9);
      if (pick == 0)
         data = '0;
      else if (pick == 1)
         data = 32'hFFFF_FFFF;
      else
         data = $urandom_range(0, 60);
      csr_write(REG_COOLDOWN_US, data);
      csr_write(REG_EXT_ENABLE_USED, $urandom);
      // every third segment walks the full mode range
      if (segment_index % 3 == 0)
         mode = 3'(segment_index % 8);
      else
         mode = 3'($urandom_range(1, 4));
      data = $urandom;
      data[2:0] = mode;
      csr_write(REG_POWER_MODE, data);
      segment_index++;
   endtask

   function automatic item_type make_sequence_item();
      int       pick;
      int       cur;
      logic [1:0] req;
      pick = $urandom_range(0, 99);
      if (pick < 5)
         return make_item(1'($urandom), $urandom, 2'($urandom_range(0, 3)), $urandom,
                          1'($urandom));
      now_track += ($urandom_range(0, 99) < 3) ? $urandom : $urandom_range(0, 30);
      if (pick < 15) begin
         req = ($urandom_range(0, 9) < 7) ? 2'($urandom_range(REQ_FWD, REQ_REV))
                                          : 2'($urandom_range(0, 3));
         return make_item(CMD_SET, $urandom, req, now_track, 1'($urandom));
      end
      // sample near the threshold: above, at, below, or far negative
      pick = $urandom_range(0, 9);
      if (pick < 3)
         cur = int'(segment_limit) + 1 + $urandom_range(0, 20);
      else if (pick == 3)
         cur = int'(segment_limit);
      else if (pick < 9)
         cur = int'(segment_limit) - 1 - $urandom_range(0, 20);
      else
         cur = -int'($urandom_range(0, 8388608));
      if (cur > 8388607)
         cur = 8388607;
      if (cur < -8388608)
         cur = -8388608;
      return make_item(CMD_SAMPLE, cur, 2'($urandom), now_track, 1'($urandom));
   endfunction

   task automatic test_random_traffic(input int idle_pct, input int stall_pct);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int s = 0; s < SEGMENTS; s++) begin
         configure_segment();
         now_track += $urandom_range(0, 30);
         send_item(make_item(CMD_SET, $urandom, 2'($urandom_range(REQ_FWD, REQ_REV)),
                             now_track, 1'($urandom)));
         for (int n = 1; n < SEGMENT_LEN; n++)
            send_item(make_sequence_item());
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset = 1'b0;
      test_power_requests();
      test_trip_and_recovery();
      test_mode_gating();
      test_random_traffic(9, 76);
      test_random_traffic(76, 9);
      test_random_traffic(0, 0);
      wait_drained();
      repeat (8) @(posedge clock);
      if (output_errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/tpoc_pkg.sv
hw/rtl/tpoc_csr.sv
hw/rtl/tpoc_step.sv
hw/rtl/track_power_overload_controller_core.sv
hw/rtl/tpoc_checker.sv
dv/tb_track_power_overload_controller_core.sv
